// ===== src/connection_slot_pool_top_macros.svh =====
// ----------------------------------------------------------------------------
// connection slot pool assertion macros
// shared property wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef CONNECTION_SLOT_POOL_TOP_MACROS_SVH
`define CONNECTION_SLOT_POOL_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CSP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl : assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("connection slot pool check failed");
`define CSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl : assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("connection slot pool check failed");
`else
`define CSP_ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define CSP_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== src/csp_pkg.sv =====
// ----------------------------------------------------------------------------
// csp_pkg
// constants, codes and controller/datapath types of the connection slot pool
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int SLOTS      = 16;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int LIM_W      = 5;
	localparam int CMP_W      = ((CNT_W + 1) > LIM_W) ? (CNT_W + 1) : LIM_W;
	localparam int ID_W       = 32;
	localparam int CMD_W      = 2;
	localparam int STS_W      = 2;
	localparam int TOT_W      = 5;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_USED_W = STS_W + ID_W + ID_W + TOT_W + TOT_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int PAD_W      = OUT_DATA_W - OUT_USED_W;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

	localparam logic [1:0] SLOT_FREE   = 2'd0;
	localparam logic [1:0] SLOT_IDLE   = 2'd1;
	localparam logic [1:0] SLOT_ACTIVE = 2'd2;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RESET   = 2'd3;

	localparam logic [STS_W-1:0] RES_OK        = 2'd0;
	localparam logic [STS_W-1:0] RES_EXHAUSTED = 2'd1;
	localparam logic [STS_W-1:0] RES_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} csp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} csp_sts_t;

	function automatic logic [TOT_W-1:0] sat_total(input logic [CNT_W-1:0] v);
		logic [CMP_W-1:0] w;
		w = CMP_W'(v);
		sat_total = (w > CMP_W'(31)) ? TOT_W'(31) : w[TOT_W-1:0];
	endfunction

endpackage

// ===== src/csp_ctrl.sv =====
// ----------------------------------------------------------------------------
// csp_ctrl
// command sequencer: take item, scan the slot table, commit the result
// ----------------------------------------------------------------------------
module csp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  csp_pkg::csp_sts_t sts,
	output csp_pkg::csp_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		s_tready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== src/csp_dpath.sv =====
// ----------------------------------------------------------------------------
// csp_dpath
// slot table, counters, scan compare and result register
// ----------------------------------------------------------------------------
module csp_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  csp_pkg::csp_cmd_t                  cmd,
	output csp_pkg::csp_sts_t                  sts,
	input  logic [csp_pkg::CMD_W-1:0]          in_command,
	input  logic [csp_pkg::ID_W-1:0]           in_conn_id,
	input  logic                               cfg_valid,
	input  logic [csp_pkg::LIM_W-1:0]          cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [csp_pkg::OUT_DATA_W-1:0]     out_data
);

	// slot table, state doubles as valid for id and served
	logic [1:0]               slot_state_q  [csp_pkg::SLOTS];
	logic [csp_pkg::ID_W-1:0] slot_id_q     [csp_pkg::SLOTS];
	logic [csp_pkg::ID_W-1:0] slot_served_q [csp_pkg::SLOTS];

	logic [csp_pkg::CMD_W-1:0] cmd_q;
	logic [csp_pkg::ID_W-1:0]  conn_id_q;
	logic [csp_pkg::IDX_W-1:0] scan_idx_q;
	logic                      hit_q;
	logic [csp_pkg::IDX_W-1:0] hit_idx_q;
	logic [1:0]                hit_state_q;
	logic [csp_pkg::ID_W-1:0]  hit_id_q;
	logic [csp_pkg::ID_W-1:0]  hit_served_q;
	logic                      free_hit_q;
	logic [csp_pkg::IDX_W-1:0] free_idx_q;
	logic [csp_pkg::ID_W-1:0]  next_id_q;
	logic [csp_pkg::CNT_W-1:0] active_q;
	logic [csp_pkg::CNT_W-1:0] idle_q;
	logic [csp_pkg::LIM_W-1:0] limit_q;
	logic                      out_valid_q;
	logic [csp_pkg::OUT_DATA_W-1:0] out_data_q;

	logic [1:0]               rd_state;
	logic [csp_pkg::ID_W-1:0] rd_id;
	logic [csp_pkg::ID_W-1:0] rd_served;
	logic                     scan_match;

	logic [csp_pkg::CMP_W-1:0] limit_eff;
	logic [csp_pkg::CMP_W-1:0] live;
	logic [csp_pkg::ID_W-1:0]  next_id_inc;

	logic [csp_pkg::STS_W-1:0] res_status;
	logic [csp_pkg::ID_W-1:0]  res_gid;
	logic [csp_pkg::ID_W-1:0]  res_served;
	logic [csp_pkg::CNT_W-1:0] active_d;
	logic [csp_pkg::CNT_W-1:0] idle_d;
	logic [csp_pkg::ID_W-1:0]  next_id_d;
	logic                      clear_all;
	logic                      wr_state_en;
	logic [csp_pkg::IDX_W-1:0] wr_idx;
	logic [1:0]                wr_state;
	logic                      wr_id_en;
	logic                      wr_served_en;
	logic [csp_pkg::ID_W-1:0]  wr_served;

	assign rd_state  = slot_state_q[scan_idx_q];
	assign rd_id     = slot_id_q[scan_idx_q];
	assign rd_served = slot_served_q[scan_idx_q];

	always_comb begin
		case (cmd_q)
			csp_pkg::CMD_ACQUIRE: scan_match = (rd_state == csp_pkg::SLOT_IDLE);
			csp_pkg::CMD_RELEASE: scan_match = (rd_state == csp_pkg::SLOT_ACTIVE) &&
			                                   (rd_id == conn_id_q);
			csp_pkg::CMD_CLOSE:   scan_match = (rd_state != csp_pkg::SLOT_FREE) &&
			                                   (rd_id == conn_id_q);
			default:              scan_match = 1'b0;
		endcase
	end

	assign sts.scan_last = (scan_idx_q == csp_pkg::IDX_W'(csp_pkg::SLOTS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign limit_eff   = (csp_pkg::CMP_W'(limit_q) > csp_pkg::CMP_W'(csp_pkg::SLOTS)) ?
	                     csp_pkg::CMP_W'(csp_pkg::SLOTS) : csp_pkg::CMP_W'(limit_q);
	assign live        = csp_pkg::CMP_W'(active_q) + csp_pkg::CMP_W'(idle_q);
	assign next_id_inc = next_id_q + csp_pkg::ID_W'(1);

	always_comb begin
		res_status   = csp_pkg::RES_OK;
		res_gid      = '0;
		res_served   = '0;
		active_d     = active_q;
		idle_d       = idle_q;
		next_id_d    = next_id_q;
		clear_all    = 1'b0;
		wr_state_en  = 1'b0;
		wr_idx       = hit_idx_q;
		wr_state     = csp_pkg::SLOT_FREE;
		wr_id_en     = 1'b0;
		wr_served_en = 1'b0;
		wr_served    = '0;
		case (cmd_q)
			csp_pkg::CMD_ACQUIRE: begin
				if (hit_q) begin
					wr_state_en = 1'b1;
					wr_state    = csp_pkg::SLOT_ACTIVE;
					active_d    = active_q + csp_pkg::CNT_W'(1);
					if (idle_q != '0) begin
						idle_d = idle_q - csp_pkg::CNT_W'(1);
					end
					res_gid    = hit_id_q;
					res_served = hit_served_q;
				end else if (live >= limit_eff || !free_hit_q) begin
					res_status = csp_pkg::RES_EXHAUSTED;
				end else begin
					wr_idx       = free_idx_q;
					wr_state_en  = 1'b1;
					wr_state     = csp_pkg::SLOT_ACTIVE;
					wr_id_en     = 1'b1;
					wr_served_en = 1'b1;
					active_d     = active_q + csp_pkg::CNT_W'(1);
					next_id_d    = (next_id_inc == '0) ? csp_pkg::ID_W'(1) : next_id_inc;
					res_gid      = next_id_q;
				end
			end
			csp_pkg::CMD_RELEASE: begin
				if (hit_q) begin
					wr_state_en  = 1'b1;
					wr_state     = csp_pkg::SLOT_IDLE;
					wr_served_en = 1'b1;
					wr_served    = hit_served_q + csp_pkg::ID_W'(1);
					if (active_q != '0) begin
						active_d = active_q - csp_pkg::CNT_W'(1);
					end
					idle_d = idle_q + csp_pkg::CNT_W'(1);
				end else begin
					res_status = csp_pkg::RES_NOT_FOUND;
				end
			end
			csp_pkg::CMD_CLOSE: begin
				if (hit_q) begin
					wr_state_en = 1'b1;
					wr_state    = csp_pkg::SLOT_FREE;
					if (hit_state_q == csp_pkg::SLOT_ACTIVE && active_q != '0) begin
						active_d = active_q - csp_pkg::CNT_W'(1);
					end else if (hit_state_q == csp_pkg::SLOT_IDLE && idle_q != '0) begin
						idle_d = idle_q - csp_pkg::CNT_W'(1);
					end
				end else begin
					res_status = csp_pkg::RES_NOT_FOUND;
				end
			end
			default: begin
				clear_all = 1'b1;
				active_d  = '0;
				idle_d    = '0;
				next_id_d = csp_pkg::ID_W'(1);
			end
		endcase
	end

	// slot states, counters, limit, scan flags and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csp_pkg::SLOTS; i++) begin
				slot_state_q[i] <= csp_pkg::SLOT_FREE;
			end
			next_id_q   <= csp_pkg::ID_W'(1);
			active_q    <= '0;
			idle_q      <= '0;
			limit_q     <= csp_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			free_hit_q  <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.start) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				free_hit_q <= 1'b0;
			end else if (cmd.scan) begin
				scan_idx_q <= scan_idx_q + csp_pkg::IDX_W'(1);
				if (scan_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (rd_state == csp_pkg::SLOT_FREE && !free_hit_q) begin
					free_hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (clear_all) begin
					for (int i = 0; i < csp_pkg::SLOTS; i++) begin
						slot_state_q[i] <= csp_pkg::SLOT_FREE;
					end
				end else if (wr_state_en) begin
					slot_state_q[wr_idx] <= wr_state;
				end
				next_id_q   <= next_id_d;
				active_q    <= active_d;
				idle_q      <= idle_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload: item capture, scan hits, id and served storage, result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_q     <= in_command;
			conn_id_q <= in_conn_id;
		end
		if (cmd.scan) begin
			if (scan_match && !hit_q) begin
				hit_idx_q    <= scan_idx_q;
				hit_state_q  <= rd_state;
				hit_id_q     <= rd_id;
				hit_served_q <= rd_served;
			end
			if (rd_state == csp_pkg::SLOT_FREE && !free_hit_q) begin
				free_idx_q <= scan_idx_q;
			end
		end
		if (cmd.commit) begin
			if (wr_id_en) begin
				slot_id_q[wr_idx] <= next_id_q;
			end
			if (wr_served_en) begin
				slot_served_q[wr_idx] <= wr_served;
			end
			out_data_q <= {{csp_pkg::PAD_W{1'b0}},
			               csp_pkg::sat_total(idle_d),
			               csp_pkg::sat_total(active_d),
			               res_served, res_gid, res_status};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/connection_slot_pool_top.sv =====
// ----------------------------------------------------------------------------
// connection_slot_pool_top
// connection slot pool: acquire, release, close and reset over a slot table
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_*       in         tuser command, tdata conn_id
// m_*       out        tdata status, granted_id, served_count, totals
// cfg_*     in         connection_limit
//
// an item is accepted, then the slot table is scanned entry by entry
// through its single read port, then the result is committed
// the commit waits while the previous result is still held on m_*
// a new item is taken once the commit is done, even if the result waits
// arst_n resets the slot states, counters, next id and limit at once
// ----------------------------------------------------------------------------
`include "connection_slot_pool_top_macros.svh"

module connection_slot_pool_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [csp_pkg::IN_DATA_W-1:0]  s_tdata,   // conn_id
	input  logic [csp_pkg::CMD_W-1:0]      s_tuser,   // command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status, granted_id, served_count, active_total, idle_total, zero pad
	output logic [csp_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [csp_pkg::LIM_W-1:0]      cfg_data
);

	csp_pkg::csp_cmd_t ctl_cmd;
	csp_pkg::csp_sts_t ctl_sts;

	assign cfg_ready = 1'b1;

	csp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (ctl_sts),
		.cmd      (ctl_cmd)
	);

	csp_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl_cmd),
		.sts        (ctl_sts),
		.in_command (s_tuser),
		.in_conn_id (s_tdata[csp_pkg::ID_W-1:0]),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

	`CSP_ASSERT_NEXT(a_accept_blocks, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`CSP_ASSERT_SAME(a_commit_free, clk, arst_n, ctl_cmd.commit, ctl_sts.out_free)
	`CSP_ASSERT_NEXT(a_commit_shows, clk, arst_n, ctl_cmd.commit, m_tvalid)

endmodule

// ===== tb/connection_slot_pool_top_tb.sv =====
// ----------------------------------------------------------------------------
// connection_slot_pool_top_tb
// Drives acquire, release, close and reset-pool commands into the slot pool
// under several connection limits, with random gaps on both streams. A shadow
// of the slot table predicts each result, and every result is checked field
// by field in arrival order.
// ----------------------------------------------------------------------------
module connection_slot_pool_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csp_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [ID_W-1:0]  id;
	} pool_cmd_t;

	// same layout as m_tdata, lowest field last
	typedef struct packed {
		logic [PAD_W-1:0] pad;
		logic [TOT_W-1:0] idle_total;
		logic [TOT_W-1:0] active_total;
		logic [ID_W-1:0]  served_count;
		logic [ID_W-1:0]  granted_id;
		logic [STS_W-1:0] status;
	} pool_reply_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // conn_id
	logic [CMD_W-1:0]      s_tuser = '0;   // command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// status, granted_id, served_count, active_total, idle_total, zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [LIM_W-1:0]      cfg_data = '0;

	connection_slot_pool_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the slot table
	logic [ID_W-1:0]  slot_cid [SLOTS];
	logic [1:0]       slot_st [SLOTS];
	logic [ID_W-1:0]  slot_srv [SLOTS];
	logic [ID_W-1:0]  next_cid;
	int               n_active;
	int               n_idle;
	logic [LIM_W-1:0] pool_limit = LIMIT_RESET;

	pool_cmd_t   pending_cmds[$];
	pool_reply_t expected_replies[$];

	logic calm = 1'b1;
	logic long_hold = 1'b0;
	int   send_gap = 0;
	int   stall_left = 0;
	logic hold_item;
	int   n_sent = 0;
	int   n_replies = 0;
	int   n_errors = 0;
	int   n_exhausted = 0;
	int   n_missing = 0;
	int   n_limits = 0;

	logic [LIM_W-1:0] phase_limits [9] = '{5'd31, 5'd1, 5'd7, 5'd16, 5'd0, 5'd12,
		5'd24, 5'd3, 5'd16};

	task automatic clear_pool();
		for (int i = 0; i < SLOTS; i++) begin
			slot_cid[i] = '0;
			slot_st[i] = SLOT_FREE;
			slot_srv[i] = '0;
		end
		next_cid = 1;
		n_active = 0;
		n_idle = 0;
	endtask

	task automatic apply_command(input pool_cmd_t c);
		pool_reply_t r;
		int lim;
		int hit;
		r = '0;
		r.status = RES_OK;
		lim = (pool_limit > SLOTS) ? SLOTS : int'(pool_limit);
		hit = -1;
		case (c.cmd)
		CMD_ACQUIRE: begin
			for (int i = 0; i < SLOTS; i++)
				if (hit < 0 && slot_st[i] == SLOT_IDLE && slot_cid[i] != 0)
					hit = i;
			if (hit >= 0) begin
				slot_st[hit] = SLOT_ACTIVE;
				n_active++;
				if (n_idle > 0)
					n_idle--;
				r.granted_id = slot_cid[hit];
				r.served_count = slot_srv[hit];
			end else if (n_active + n_idle >= lim) begin
				r.status = RES_EXHAUSTED;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_cid[i] == 0)
						hit = i;
				if (hit < 0) begin
					r.status = RES_EXHAUSTED;
				end else begin
					slot_cid[hit] = next_cid;
					next_cid++;
					if (next_cid == 0)
						next_cid = 1;
					slot_st[hit] = SLOT_ACTIVE;
					slot_srv[hit] = '0;
					n_active++;
					r.granted_id = slot_cid[hit];
				end
			end
		end
		CMD_RELEASE: begin
			if (c.id != 0)
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_cid[i] == c.id && slot_st[i] == SLOT_ACTIVE)
						hit = i;
			if (hit < 0) begin
				r.status = RES_NOT_FOUND;
			end else begin
				slot_st[hit] = SLOT_IDLE;
				slot_srv[hit]++;
				if (n_active > 0)
					n_active--;
				n_idle++;
			end
		end
		CMD_CLOSE: begin
			if (c.id != 0)
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && slot_cid[i] == c.id)
						hit = i;
			if (hit < 0) begin
				r.status = RES_NOT_FOUND;
			end else begin
				if (slot_st[hit] == SLOT_ACTIVE && n_active > 0)
					n_active--;
				else if (slot_st[hit] == SLOT_IDLE && n_idle > 0)
					n_idle--;
				slot_cid[hit] = '0;
				slot_st[hit] = SLOT_FREE;
				slot_srv[hit] = '0;
			end
		end
		default: begin
			clear_pool();
		end
		endcase
		r.active_total = TOT_W'(n_active > 31 ? 31 : n_active);
		r.idle_total = TOT_W'(n_idle > 31 ? 31 : n_idle);
		if (r.status == RES_EXHAUSTED)
			n_exhausted++;
		if (r.status == RES_NOT_FOUND)
			n_missing++;
		expected_replies.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] seen);
		if (seen !== want) begin
			$error("%s: expected %0d, got %0d", name, want, seen);
			n_errors++;
		end
	endtask

	task automatic check_reply(input pool_reply_t got);
		pool_reply_t want;
		if (expected_replies.size() == 0) begin
			$error("result with nothing outstanding: status %0d granted_id %0d",
				got.status, got.granted_id);
			n_errors++;
		end else begin
			want = expected_replies.pop_front();
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("granted_id", want.granted_id, got.granted_id);
			check_field("served_count", want.served_count, got.served_count);
			check_field("active_total", 32'(want.active_total), 32'(got.active_total));
			check_field("idle_total", 32'(want.idle_total), 32'(got.idle_total));
		end
	endtask

	// command stream
	always @(posedge clk) begin
		if (arst_n) begin
			hold_item = s_tvalid;
			if (s_tvalid && s_tready) begin
				apply_command(pending_cmds[0]);
				void'(pending_cmds.pop_front());
				n_sent++;
				hold_item = 1'b0;
			end
			if (hold_item) begin
				// item still on offer
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0 && !calm && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 13);
				s_tvalid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tuser <= pending_cmds[0].cmd;
				s_tdata <= pending_cmds[0].id;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result stream
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_reply(pool_reply_t'(m_tdata));
				n_replies++;
			end
			if (long_hold) begin
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 13);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the pool backs up into its input
	initial begin
		wait (n_replies >= 300);
		@(negedge clk);
		long_hold = 1'b1;
		repeat (400) @(negedge clk);
		long_hold = 1'b0;
	end

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
		pool_cmd_t c;
		c.cmd = cmd;
		c.id = id;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(input int count);
		pool_cmd_t c;
		int roll;
		int id_hi;
		int id_lo;
		id_hi = 1;
		queue_cmd(CMD_RESET, $urandom);
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			id_lo = (id_hi > 20) ? id_hi - 20 : 1;
			c.id = $urandom;
			if (roll < 42) begin
				c.cmd = CMD_ACQUIRE;
			end else if (roll < 72) begin
				c.cmd = CMD_RELEASE;
				c.id = $urandom_range(id_lo, id_hi);
			end else if (roll < 86) begin
				c.cmd = CMD_CLOSE;
				c.id = $urandom_range(id_lo, id_hi);
			end else if (roll < 88) begin
				c.cmd = CMD_RESET;
			end else if (roll < 95) begin
				c.cmd = CMD_W'($urandom_range(0, 3));
				if (roll < 91)
					c.id = '0;
			end else begin
				c.cmd = (roll < 98) ? CMD_RELEASE : CMD_CLOSE;
				c.id = id_hi + $urandom_range(1, 8);
			end
			if (c.cmd == CMD_ACQUIRE)
				id_hi++;
			if (c.cmd == CMD_RESET)
				id_hi = 1;
			pending_cmds.push_back(c);
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || s_tvalid || expected_replies.size() != 0);
		repeat (24) @(posedge clk);
	endtask

	task automatic set_limit(input logic [LIM_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		pool_limit = v;
		n_limits++;
	endtask

	initial begin
		clear_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// id zero, unknown ids, reuse of an idle slot, double release and close
		queue_cmd(CMD_RELEASE, 32'h0);
		queue_cmd(CMD_CLOSE, 32'h0);
		queue_cmd(CMD_RELEASE, 32'hFFFF_FFFF);
		queue_cmd(CMD_CLOSE, 32'hFFFF_FFFF);
		queue_cmd(CMD_ACQUIRE, 32'hFFFF_FFFF);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		queue_cmd(CMD_RELEASE, 32'd1);
		queue_cmd(CMD_RELEASE, 32'd1);
		queue_cmd(CMD_ACQUIRE, 32'h5555_5555);
		queue_cmd(CMD_RELEASE, 32'd2);
		queue_cmd(CMD_CLOSE, 32'd2);
		queue_cmd(CMD_CLOSE, 32'd2);
		queue_cmd(CMD_CLOSE, 32'd1);
		queue_cmd(CMD_RESET, 32'hAAAA_AAAA);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		drain();

		// zero limit: idle reuse still works, a new open does not
		set_limit(5'd0);
		queue_cmd(CMD_RELEASE, 32'd1);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		drain();

		set_limit(5'd2);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		queue_cmd(CMD_ACQUIRE, 32'h0);
		queue_cmd(CMD_RESET, 32'h0);
		drain();

		calm = 1'b0;
		foreach (phase_limits[p]) begin
			if (p == $size(phase_limits) - 1)
				calm = 1'b1;
			set_limit(phase_limits[p]);
			queue_random(165);
			drain();
		end

		if (expected_replies.size() != 0) begin
			$error("%0d results never arrived", expected_replies.size());
			n_errors++;
		end
		$display("%0d commands over %0d limit settings, %0d results checked",
			n_sent, n_limits, n_replies);
		$display("%0d acquires exhausted, %0d ids not found", n_exhausted, n_missing);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== connection_slot_pool_top.f =====
+incdir+src
src/csp_pkg.sv
src/csp_ctrl.sv
src/csp_dpath.sv
src/connection_slot_pool_top.sv
tb/connection_slot_pool_top_tb.sv
